// File: sv/smt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_pkg - shared types and constants of the small set membership table
// Request and status codes, sequencer states, field widths, default capacity
// and the control word that the top level hands to every storage cell.
// ----------------------------------------------------------------------------
package smt_pkg;

  // Default number of entries in the store
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_QUERY  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_ALREADY    = 2'd1,
    STAT_NOT_MEMBER = 2'd2,
    STAT_FULL       = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_e;

  // Control word for one storage cell
  typedef struct packed {
    logic sample;  // capture the compare result against the incoming word
    logic valid;   // cell holds a live entry
    logic shift;   // take the upper neighbor's entry
    logic append;  // write the request value
  } cell_ctl_t;

endpackage

// File: sv/smt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_cell - one entry of the packed store
// Holds one value, compares it against the request word, takes the request value
// on an append and its upper neighbor's value when a delete closes the gap.
// ----------------------------------------------------------------------------
module smt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  smt_pkg::cell_ctl_t           ctl_i,
  input  logic [smt_pkg::VALUE_W-1:0]  value_i,
  input  logic [smt_pkg::VALUE_W-1:0]  nbr_i,
  output logic [smt_pkg::VALUE_W-1:0]  data_o,
  output logic                         match_o
);

  logic [smt_pkg::VALUE_W-1:0] data_q, data_d;
  logic                        match_q, match_d;

  // Select the next entry: shift down first, else append, else hold
  always_comb begin
    data_d = data_q;
    priority if (ctl_i.shift) begin
      data_d = nbr_i;
    end else if (ctl_i.append) begin
      data_d = value_i;
    end else begin
      data_d = data_q;
    end
  end

  // Compare only live entries
  assign match_d = ctl_i.sample ? (ctl_i.valid && (data_q == value_i)) : match_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// File: sv/small_set_membership_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_set_membership_table - set of distinct 32-bit values
// A row of storage cells with a per-cell compare and a shift-down path,
// plus an occupancy count and a two-state request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type_i and value_i with start high; the word is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done_o is high for exactly one cycle; found_o, status_o and
//   count_o are then valid until the next result; the receiver cannot stall it.
// Timing:
//   At the accepting edge every cell compares its entry with the request word.
//   In the next cycle (busy high) the match vector is reduced, the store is
//   updated (append at the tail, or shift down above the deleted entry) and the
//   result is registered. done_o rises the cycle after, with busy already low,
//   so a new request can be accepted while done_o is high, but not while busy.
//   The thermometer decode of the match vector marks the matching entry and
//   every entry above it for the shift.
// Reset:
//   rst_ni clears the occupancy count, the sequencer and the result strobe.
//   The stored entries are not cleared; an entry is live only below the count.
// ----------------------------------------------------------------------------
module small_set_membership_table #(
  parameter int unsigned CAPACITY = smt_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic        [smt_pkg::REQ_W-1:0]    req_type_i,
  input  logic signed [smt_pkg::VALUE_W-1:0]  value_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic        [smt_pkg::STAT_W-1:0]   status_o,
  output logic        [smt_pkg::COUNT_W-1:0]  count_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  smt_pkg::state_e              state_q, state_d;
  smt_pkg::req_e                req_q, req_d;
  logic [smt_pkg::VALUE_W-1:0]  value_q, value_d;
  logic [OCC_W-1:0]             occ_q, occ_d;
  logic                         done_q, done_d;
  logic                         found_q, found_d;
  smt_pkg::status_e             status_q, status_d;
  logic [smt_pkg::COUNT_W-1:0]  count_q, count_d;

  logic                         accept;
  logic                         eval;
  logic                         present;
  logic                         do_shift;
  logic                         do_append;
  logic [CAPACITY-1:0]          match_vec;
  logic [CAPACITY-1:0]          above_hit;
  logic [smt_pkg::VALUE_W-1:0]  cell_value;
  logic [smt_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
  logic [OCC_W+smt_pkg::COUNT_W-1:0] occ_ext;

  assign accept = start && (state_q == smt_pkg::S_IDLE);
  assign eval   = (state_q == smt_pkg::S_EVAL);
  assign busy   = eval;

  // Compare against the live word at acceptance, write the held word later
  assign cell_value = eval ? value_q : value_i;

  // Entries are distinct, so the match vector is one-hot or zero
  assign present   = |match_vec;
  assign above_hit = ~(match_vec - CAPACITY'(1));

  // Row of storage cells, each fed by its upper neighbor, the top cell by zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smt_pkg::cell_ctl_t           ctl;
    logic [smt_pkg::VALUE_W-1:0]  nbr;

    if (i == CAPACITY - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    assign ctl.sample = accept;
    assign ctl.valid  = OCC_W'(i) < occ_q;
    assign ctl.shift  = do_shift && above_hit[i];
    assign ctl.append = do_append && (occ_q == OCC_W'(i));

    smt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .value_i (cell_value),
      .nbr_i   (nbr),
      .data_o  (cell_data[i]),
      .match_o (match_vec[i])
    );
  end

  // Sequencer: next state, store update and result
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    value_d   = value_q;
    occ_d     = occ_q;
    done_d    = 1'b0;
    found_d   = found_q;
    status_d  = status_q;
    do_shift  = 1'b0;
    do_append = 1'b0;

    unique case (state_q)
      smt_pkg::S_IDLE: begin
        if (start) begin
          req_d   = smt_pkg::req_e'(req_type_i);
          value_d = value_i;
          state_d = smt_pkg::S_EVAL;
        end
      end
      smt_pkg::S_EVAL: begin
        found_d  = present;
        status_d = smt_pkg::STAT_OK;
        unique case (req_q)
          smt_pkg::REQ_QUERY: begin
            if (!present) status_d = smt_pkg::STAT_NOT_MEMBER;
          end
          smt_pkg::REQ_INSERT: begin
            priority if (present) begin
              status_d = smt_pkg::STAT_ALREADY;
            end else if (occ_q == OCC_W'(CAPACITY)) begin
              status_d = smt_pkg::STAT_FULL;
            end else begin
              do_append = 1'b1;
              occ_d     = occ_q + OCC_W'(1);
            end
          end
          smt_pkg::REQ_DELETE: begin
            if (present) begin
              do_shift = 1'b1;
              occ_d    = occ_q - OCC_W'(1);
            end else begin
              status_d = smt_pkg::STAT_NOT_MEMBER;
            end
          end
          smt_pkg::REQ_CLEAR: begin
            occ_d = '0;
          end
          default: ;
        endcase
        done_d  = 1'b1;
        state_d = smt_pkg::S_IDLE;
      end
      default: state_d = smt_pkg::S_IDLE;
    endcase
  end

  // Report the low bits of the new occupancy
  assign occ_ext = {{smt_pkg::COUNT_W{1'b0}}, occ_d};
  assign count_d = eval ? occ_ext[smt_pkg::COUNT_W-1:0] : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smt_pkg::S_IDLE;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
    end
  end

  // Hold request and result words
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    value_q  <= value_d;
    found_q  <= found_d;
    status_q <= status_d;
    count_q  <= count_d;
  end

  assign done_o   = done_q;
  assign found_o  = found_q;
  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

// File: sv/smt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smt_checker - port-level checks of the small set membership table
// Watches the request handshake, the result strobe and status consistency.
// ----------------------------------------------------------------------------
module smt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic                                found_o,
  input logic        [smt_pkg::STAT_W-1:0]   status_o
);

  // An accepted word yields busy, then a result
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  a_accept_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("no result two cycles after an accepted word");

  // Busy lasts one cycle and the strobe never repeats
  a_busy_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o))
    else $error("busy held too long or result missing");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // Status agrees with the found flag
  a_status_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (((status_o == smt_pkg::STAT_ALREADY) && found_o) ||
                ((status_o == smt_pkg::STAT_NOT_MEMBER) && !found_o) ||
                ((status_o == smt_pkg::STAT_FULL) && !found_o) ||
                (status_o == smt_pkg::STAT_OK)))
    else $error("status contradicts found flag");

endmodule

bind small_set_membership_table smt_checker u_smt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .found_o  (found_o),
  .status_o (status_o)
);
